FILE: design/bffa_pkg.sv
`timescale 1ns / 1ps

package bffa_pkg;

    // Default sizing handed to the top level parameters
    localparam int DEF_MAX_BLOCKS = 8192;
    localparam int DEF_MAX_INODES = 2048;
    localparam int DEF_SCAN_WIDTH = 32;

    // Fixed field widths
    localparam int IDX_W      = 13;
    localparam int ST_W       = 2;
    localparam int BCNT_W     = 14;
    localparam int ICNT_W     = 12;
    localparam int BSTART_W   = 13;
    localparam int ISTART_W   = 11;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_INODE_COUNT = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_START = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_INODE_START = CFG_ADDR_W'(3);

    // Register reset values
    localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(8192);
    localparam logic [ICNT_W-1:0] ICNT_RESET = ICNT_W'(2048);
    localparam int START_RESET [8] = '{0, 0, 0, 0, 11, 11, 11, 11};

    // Request codes
    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_FREE   = 1'b1;
    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_INODE = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DOUBLE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FREE_CHK,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;      // capture request and config
        logic    issue;     // read the current scan row
        logic    wr_set;    // mark the found entry used
        logic    wr_clr;    // mark the freed entry free
        logic    clr_wr;    // clearing pass write
        logic    res_load;  // capture result
        t_status res_code;
        logic    out_load;  // move result to output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cmd_free;
        logic empty;
        logic oob;
        logic found;
        logic last_chk;
        logic iss_done;
        logic bit_set;
        logic clr_last;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: design/bffa_if.sv
`timescale 1ns / 1ps

// Request channel
interface bffa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic                       kind;
    logic [bffa_pkg::IDX_W-1:0] index;

    modport source (output valid, cmd, kind, index, input ready);
    modport sink   (input valid, cmd, kind, index, output ready);
endinterface

// Result channel
interface bffa_res_if;
    logic                       valid;
    logic                       ready;
    logic [bffa_pkg::IDX_W-1:0] result_index;
    logic [bffa_pkg::ST_W-1:0]  status;

    modport source (output valid, result_index, status, input ready);
    modport sink   (input valid, result_index, status, output ready);
endinterface

// Config write channel
interface bffa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bffa_pkg::CFG_ADDR_W-1:0] addr;
    logic [bffa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: design/bitmap_first_fit_allocator_top.sv
`timescale 1ns / 1ps

// Channel  Modport  Handshake      Payload
// i_req    sink     valid/ready    cmd, kind, index
// o_res    source   valid/ready    result_index, status
// i_cfg    sink     valid/ready    addr, data (always ready)
//
// Free request: DISPATCH, FREE_CHK (skipped for an index outside the pool), then RESULT.
// Allocate: DISPATCH, then SCAN reads the pool's SCAN_WIDTH-wide map rows in turn
// until a free entry is found or all are checked, then RESULT (empty pool: no SCAN).
// After reset a clearing pass zeroes all max(MAX_BLOCKS, MAX_INODES) / SCAN_WIDTH rows
// (256 by default) of both maps; requests wait, config writes are taken.
// A new request is accepted while the previous result waits in the output register.

module bitmap_first_fit_allocator_top #(
    parameter int MAX_BLOCKS = bffa_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_INODES = bffa_pkg::DEF_MAX_INODES,
    parameter int SCAN_WIDTH = bffa_pkg::DEF_SCAN_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bffa_req_if.sink   i_req,
    bffa_res_if.source o_res,
    bffa_cfg_if.sink   i_cfg
);
    import bffa_pkg::*;

    logic [BCNT_W-1:0]   r_block_count;
    logic [ICNT_W-1:0]   r_inode_count;
    logic [BSTART_W-1:0] r_block_start;
    logic [ISTART_W-1:0] r_inode_start;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Config registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BCNT_RESET;
            r_inode_count <= ICNT_RESET;
            r_block_start <= BSTART_W'(START_RESET[0]);
            r_inode_start <= ISTART_W'(START_RESET[4]);
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_BLOCK_COUNT: r_block_count <= i_cfg.data[BCNT_W-1:0];
                REG_INODE_COUNT: r_inode_count <= i_cfg.data[ICNT_W-1:0];
                REG_BLOCK_START: r_block_start <= i_cfg.data[BSTART_W-1:0];
                REG_INODE_START: r_inode_start <= i_cfg.data[ISTART_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bffa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_INODES (MAX_INODES),
        .SCAN_WIDTH (SCAN_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_req_cmd      (i_req.cmd),
        .i_req_kind     (i_req.kind),
        .i_req_index    (i_req.index),
        .i_block_count  (r_block_count),
        .i_inode_count  (r_inode_count),
        .i_block_start  (r_block_start),
        .i_inode_start  (r_inode_start),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_result_index (o_res.result_index),
        .o_status       (o_res.status)
    );

endmodule

FILE: design/bffa_ctrl.sv
`timescale 1ns / 1ps

module bffa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bffa_pkg::t_dp_stat i_stat,
    output bffa_pkg::t_dp_cmd  o_cmd
);
    import bffa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.cmd_free) begin
                    if (i_stat.oob) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = ST_DOUBLE;
                        n_state        = S_RESULT;
                    end else begin
                        o_cmd.issue = 1'b1;
                        n_state     = S_FREE_CHK;
                    end
                end else if (i_stat.empty) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_FULL;
                    n_state        = S_RESULT;
                end else begin
                    o_cmd.issue = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // reads keep streaming; the row in flight at a hit is dropped
                o_cmd.issue = !i_stat.iss_done;
                if (i_stat.found) begin
                    o_cmd.wr_set   = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_OK;
                    n_state        = S_RESULT;
                end else if (i_stat.last_chk) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_FULL;
                    n_state        = S_RESULT;
                end
            end
            S_FREE_CHK: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.bit_set) begin
                    o_cmd.wr_clr   = 1'b1;
                    o_cmd.res_code = ST_OK;
                end else begin
                    o_cmd.res_code = ST_DOUBLE;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A scan is started only on a pool that has entries
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_stat.empty)
        else $error("scan running on an empty pool");

    // Requests are not taken until the clearing pass has finished
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR) || (r_state == S_IDLE))
        else $error("left clearing pass early");

endmodule

FILE: design/bffa_dp.sv
`timescale 1ns / 1ps

module bffa_dp #(
    parameter int MAX_BLOCKS = bffa_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_INODES = bffa_pkg::DEF_MAX_INODES,
    parameter int SCAN_WIDTH = bffa_pkg::DEF_SCAN_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bffa_pkg::t_dp_cmd             i_cmd,
    output bffa_pkg::t_dp_stat            o_stat,
    input  logic                          i_req_cmd,
    input  logic                          i_req_kind,
    input  logic [bffa_pkg::IDX_W-1:0]    i_req_index,
    input  logic [bffa_pkg::BCNT_W-1:0]   i_block_count,
    input  logic [bffa_pkg::ICNT_W-1:0]   i_inode_count,
    input  logic [bffa_pkg::BSTART_W-1:0] i_block_start,
    input  logic [bffa_pkg::ISTART_W-1:0] i_inode_start,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bffa_pkg::IDX_W-1:0]    o_result_index,
    output logic [bffa_pkg::ST_W-1:0]     o_status
);
    import bffa_pkg::*;

    localparam int MAX_POS  = (MAX_BLOCKS > MAX_INODES) ? MAX_BLOCKS : MAX_INODES;
    localparam int POS_W    = $clog2(MAX_POS);
    localparam int CNT_W    = $clog2(MAX_POS + 1);
    localparam int SH       = $clog2(SCAN_WIDTH);
    localparam int OFF_W    = $clog2(SCAN_WIDTH + 1);
    localparam int BLK_ROWS = MAX_BLOCKS / SCAN_WIDTH;
    localparam int INO_ROWS = MAX_INODES / SCAN_WIDTH;
    localparam int CLR_ROWS = (BLK_ROWS > INO_ROWS) ? BLK_ROWS : INO_ROWS;
    localparam int BR_W     = (BLK_ROWS > 1) ? $clog2(BLK_ROWS) : 1;
    localparam int IR_W     = (INO_ROWS > 1) ? $clog2(INO_ROWS) : 1;
    localparam int ROW_W    = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;
    localparam logic [POS_W-1:0] OFF_MASK = POS_W'(SCAN_WIDTH - 1);

    function automatic logic [ROW_W-1:0] row_of(input logic [POS_W-1:0] p);
        return ROW_W'(p >> SH);
    endfunction

    function automatic logic [OFF_W-1:0] off_of(input logic [POS_W-1:0] p);
        return OFF_W'(p & OFF_MASK);
    endfunction

    // Bitmaps, one row of SCAN_WIDTH entries per word
    logic [SCAN_WIDTH-1:0] r_bmem [BLK_ROWS];
    logic [SCAN_WIDTH-1:0] r_imem [INO_ROWS];
    logic [SCAN_WIDTH-1:0] r_bdata;
    logic [SCAN_WIDTH-1:0] r_idata;

    // Captured request
    logic             r_cmd;
    logic             r_kind;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_start;
    logic [IDX_W-1:0] r_idx;

    // Read issue and read stage
    logic [ROW_W-1:0] r_iss_row;
    logic             r_iss_ph;
    logic             r_iss_done;
    logic [ROW_W-1:0] r_rd_row;
    logic             r_rd_ph;
    logic             r_rd_vld;
    logic [ROW_W-1:0] r_clr_row;

    // Result and output registers
    logic [IDX_W-1:0] r_res_idx;
    t_status          r_res_st;
    logic             r_out_vld;
    logic [IDX_W-1:0] r_out_idx;
    t_status          r_out_st;

    logic [CNT_W-1:0]      ld_cnt;
    logic [BSTART_W-1:0]   ld_raw_start;
    logic [POS_W-1:0]      ld_start;
    logic [ROW_W-1:0]      ld_row;
    logic [ROW_W-1:0]      s_row;
    logic [OFF_W-1:0]      s_off;
    logic [POS_W-1:0]      last_pos;
    logic [ROW_W-1:0]      l_row;
    logic [OFF_W-1:0]      l_off;
    logic [OFF_W-1:0]      i_off;
    logic [OFF_W-1:0]      lo;
    logic [OFF_W-1:0]      hi;
    logic [SCAN_WIDTH-1:0] rdata;
    logic [SCAN_WIDTH-1:0] free_vec;
    logic [SCAN_WIDTH-1:0] set_vec;
    logic [SCAN_WIDTH-1:0] clr_vec;
    logic [SCAN_WIDTH-1:0] wdata;
    logic [OFF_W-1:0]      fb;
    logic [POS_W-1:0]      found_pos;
    logic                  found;
    logic                  bwe;
    logic                  iwe;
    logic [BR_W-1:0]       bwa;
    logic [IR_W-1:0]       iwa;

    // Effective count and start for the pool named by the request
    always_comb begin
        if (i_req_kind == KIND_INODE) begin
            ld_cnt = (32'(i_inode_count) > MAX_INODES) ? CNT_W'(MAX_INODES)
                                                        : CNT_W'(i_inode_count);
            ld_raw_start = BSTART_W'(i_inode_start);
        end else begin
            ld_cnt = (32'(i_block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(i_block_count);
            ld_raw_start = i_block_start;
        end
        ld_start = (32'(ld_raw_start) >= 32'(ld_cnt)) ? '0 : POS_W'(ld_raw_start);
        ld_row   = (i_req_cmd == CMD_FREE) ? row_of(POS_W'(i_req_index)) : row_of(ld_start);
    end

    // Scan window bounds
    assign s_row    = row_of(r_start);
    assign s_off    = off_of(r_start);
    assign last_pos = POS_W'(r_cnt - CNT_W'(1));
    assign l_row    = row_of(last_pos);
    assign l_off    = off_of(last_pos) + OFF_W'(1);
    assign i_off    = off_of(POS_W'(r_idx));
    assign rdata    = (r_kind == KIND_INODE) ? r_idata : r_bdata;

    // First pass runs start..end, second pass wraps 0..start
    always_comb begin
        if (!r_rd_ph) begin
            lo = (r_rd_row == s_row) ? s_off : '0;
            hi = (r_rd_row == l_row) ? l_off : OFF_W'(SCAN_WIDTH);
        end else begin
            lo = '0;
            hi = (r_rd_row == s_row) ? s_off : OFF_W'(SCAN_WIDTH);
        end
    end

    // Free entries in window, lowest one wins
    always_comb begin
        fb = '0;
        for (int b = 0; b < SCAN_WIDTH; b++) begin
            free_vec[b] = !rdata[b] && (OFF_W'(b) >= lo) && (OFF_W'(b) < hi);
            clr_vec[b]  = (OFF_W'(b) == i_off);
        end
        for (int b = SCAN_WIDTH - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                fb = OFF_W'(b);
            end
        end
        for (int b = 0; b < SCAN_WIDTH; b++) begin
            set_vec[b] = (OFF_W'(b) == fb);
        end
    end

    assign found     = r_rd_vld && (|free_vec);
    assign found_pos = (POS_W'(r_rd_row) << SH) | POS_W'(fb);

    // Memory write port
    always_comb begin
        if (i_cmd.clr_wr) begin
            wdata = '0;
        end else if (i_cmd.wr_set) begin
            wdata = rdata | set_vec;
        end else begin
            wdata = rdata & ~clr_vec;
        end
        bwe = i_cmd.clr_wr || ((i_cmd.wr_set || i_cmd.wr_clr) && (r_kind == KIND_BLOCK));
        iwe = i_cmd.clr_wr || ((i_cmd.wr_set || i_cmd.wr_clr) && (r_kind == KIND_INODE));
        bwa = i_cmd.clr_wr ? r_clr_row[BR_W-1:0] : r_rd_row[BR_W-1:0];
        iwa = i_cmd.clr_wr ? r_clr_row[IR_W-1:0] : r_rd_row[IR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (bwe) begin
            r_bmem[bwa] <= wdata;
        end
        if (i_cmd.issue) begin
            r_bdata <= r_bmem[r_iss_row[BR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (iwe) begin
            r_imem[iwa] <= wdata;
        end
        if (i_cmd.issue) begin
            r_idata <= r_imem[r_iss_row[IR_W-1:0]];
        end
    end

    // Request capture and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_req_cmd;
            r_kind  <= i_req_kind;
            r_cnt   <= ld_cnt;
            r_start <= ld_start;
            r_idx   <= i_req_index;
        end
        if (i_cmd.issue) begin
            r_rd_row <= r_iss_row;
            r_rd_ph  <= r_iss_ph;
        end
        if (i_cmd.res_load) begin
            r_res_st  <= i_cmd.res_code;
            r_res_idx <= ((i_cmd.res_code == ST_OK) && (r_cmd == CMD_ALLOC))
                         ? IDX_W'(found_pos) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_idx <= r_res_idx;
            r_out_st  <= r_res_st;
        end
    end

    // Row issue walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_iss_row <= ld_row;
            r_iss_ph  <= 1'b0;
        end else if (i_cmd.issue) begin
            if (!r_iss_ph && (r_iss_row == l_row)) begin
                r_iss_row <= '0;
                r_iss_ph  <= 1'b1;
            end else begin
                r_iss_row <= r_iss_row + ROW_W'(1);
            end
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_iss_done <= 1'b0;
            r_clr_row  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_iss_done <= 1'b0;
            end else if (i_cmd.issue && r_iss_ph && (r_iss_row == s_row)) begin
                r_iss_done <= 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Status back to controller
    always_comb begin
        o_stat.cmd_free = (r_cmd == CMD_FREE);
        o_stat.empty    = (r_cnt == '0);
        o_stat.oob      = (32'(r_idx) >= 32'(r_cnt));
        o_stat.found    = found;
        o_stat.last_chk = r_rd_vld && r_rd_ph && (r_rd_row == s_row);
        o_stat.iss_done = r_iss_done;
        o_stat.bit_set  = |(rdata & clr_vec);
        o_stat.clr_last = (r_clr_row == ROW_W'(CLR_ROWS - 1));
        o_stat.out_busy = r_out_vld && !i_out_ready;
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_index = r_out_idx;
    assign o_status       = r_out_st;

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("output overwritten while stalled");

    // An allocated entry lies inside the pool
    a_found_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_set |-> (32'(found_pos) < 32'(r_cnt)))
        else $error("allocated entry outside pool");

    // Each set or clear write to a map uses the row just read
    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_set || i_cmd.wr_clr) |-> $past(i_cmd.issue) && r_rd_vld)
        else $error("map write without a fresh read");

endmodule
